/* src/lcpp_pkg.sv */
// Shared constants, types and sine table builder for the LFO constant-power panner
package lcpp_pkg;

    // Datapath widths
    localparam int SAMPLE_WIDTH   = 24;
    localparam int PHASE_WIDTH    = 32;
    localparam int SINE_ADDR_BITS = 10;
    localparam int GAIN_WIDTH     = 16;
    localparam int PAN_WIDTH      = 16;
    localparam int DEPTH_WIDTH    = 15;
    localparam int INC_WIDTH      = 31;
    localparam int PROD_WIDTH     = SAMPLE_WIDTH + GAIN_WIDTH;
    localparam int TBL_SIZE       = 1 << SINE_ADDR_BITS;
    localparam int TBL_AW         = SINE_ADDR_BITS + 1;

    // Configuration port
    localparam int CFG_ADDR_WIDTH = 2;
    localparam int CFG_DATA_WIDTH = 31;

    // Register indexes
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_BASE_PAN  = 2'd0;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_LFO_DEPTH = 2'd1;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_LFO_INC   = 2'd2;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_LFO_EN    = 2'd3;

    // Sine table: entry k = round(32768*sin(k*pi/2/2^A)) capped at 32767, integer Q30 series
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned SeriesDiv [0:6] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210
    };

    typedef logic [GAIN_WIDTH-1:0] t_sine_tab [0:TBL_SIZE];

    function automatic t_sine_tab build_sine_tab();
        t_sine_tab       tab;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          acc;
        longint          q;
        for (int k = 0; k <= TBL_SIZE; k++) begin
            x    = (longint'(k) * HALF_PI_Q30) >> SINE_ADDR_BITS;
            x2   = (x * x) >> 30;
            term = x;
            acc  = longint'(x);
            for (int n = 1; n <= 7; n++) begin
                term = ((term * x2) >> 30) / SeriesDiv[n-1];
                if ((n % 2) == 1) begin
                    acc = acc - longint'(term);
                end else begin
                    acc = acc + longint'(term);
                end
            end
            if (acc < 0) begin
                acc = 0;
            end
            q = (acc + 64'sd16384) >>> 15;
            if (q > 32767) begin
                q = 32767;
            end
            tab[k] = q[GAIN_WIDTH-1:0];
        end
        return tab;
    endfunction

endpackage

/* src/lcpp_sine_rom.sv */
// Quarter-wave sine ROM with registered read data
module lcpp_sine_rom (
    input  logic                                 i_clk,
    input  logic [lcpp_pkg::TBL_AW-1:0]          i_addr,
    output logic [lcpp_pkg::GAIN_WIDTH-1:0]      o_data
);

    localparam lcpp_pkg::t_sine_tab SINE_TAB = lcpp_pkg::build_sine_tab();

    logic [lcpp_pkg::GAIN_WIDTH-1:0] r_data;

    // Synchronous read
    always_ff @(posedge i_clk) begin
        r_data <= SINE_TAB[i_addr];
    end

    assign o_data = r_data;

endmodule

/* src/lcpp_mul.sv */
// Shared signed multiplier with registered product
module lcpp_mul (
    input  logic                                      i_clk,
    input  logic                                      i_en,
    input  logic signed [lcpp_pkg::SAMPLE_WIDTH-1:0]  i_a,
    input  logic signed [lcpp_pkg::GAIN_WIDTH-1:0]    i_b,
    output logic signed [lcpp_pkg::PROD_WIDTH-1:0]    o_prod
);

    logic signed [lcpp_pkg::PROD_WIDTH-1:0] r_prod;

    // Product held until the next enabled multiply
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_a * i_b;
        end
    end

    assign o_prod = r_prod;

endmodule

/* src/lfo_constant_power_panner_top.sv */
// Top level: config registers, LFO phase, sequencer and output register
//
// LFO-modulated constant-power stereo panner.
// Input channel (i_in_valid / o_in_ready) carries one stereo pair per
// transaction; output channel (o_out_valid / i_out_ready) carries the gained
// pair. Left is scaled by cos and right by sin of (pan+1)*pi/4, with
// pan = base_pan, or base_pan + depth*sin(LFO phase) clamped when enabled.
// Configuration is a plain write port (i_cfg_wr_en, i_cfg_addr, i_cfg_wdata);
// it must be written only while the block is idle; the block does not check.
// Each pair steps through S_SIN_RD, S_MOD_MUL, S_PAN, S_LG_RD, S_LG_MUL,
// S_RG_MUL and S_WB; the single shared multiplier and single ROM read port
// are used three times per pair, for the LFO term and both gains.
// The input is not ready while a pair is in work; a finished pair waits in
// the sequencer if the output register is still held by a stalled receiver,
// and a new pair may be accepted while a result waits in the output register.
// Reset (synchronous, active low) clears the LFO phase, config registers,
// sequencer state and output valid flag; the ROM sine table needs no clearing.
module lfo_constant_power_panner_top (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_cfg_wr_en,
    input  logic [lcpp_pkg::CFG_ADDR_WIDTH-1:0]         i_cfg_addr,
    input  logic [lcpp_pkg::CFG_DATA_WIDTH-1:0]         i_cfg_wdata,
    input  logic                                        i_in_valid,
    output logic                                        o_in_ready,
    input  logic signed [lcpp_pkg::SAMPLE_WIDTH-1:0]    i_left_sample,
    input  logic signed [lcpp_pkg::SAMPLE_WIDTH-1:0]    i_right_sample,
    output logic                                        o_out_valid,
    input  logic                                        i_out_ready,
    output logic signed [lcpp_pkg::SAMPLE_WIDTH-1:0]    o_left_out,
    output logic signed [lcpp_pkg::SAMPLE_WIDTH-1:0]    o_right_out
);

    localparam int SW  = lcpp_pkg::SAMPLE_WIDTH;
    localparam int AW  = lcpp_pkg::TBL_AW;
    localparam int PW  = lcpp_pkg::PHASE_WIDTH;
    localparam int GW  = lcpp_pkg::GAIN_WIDTH;
    localparam int A   = lcpp_pkg::SINE_ADDR_BITS;
    localparam int SH  = PW - 2 - A;

    // Sequencer states
    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SIN_RD  = 3'd1;
    localparam logic [2:0] S_MOD_MUL = 3'd2;
    localparam logic [2:0] S_PAN     = 3'd3;
    localparam logic [2:0] S_LG_RD   = 3'd4;
    localparam logic [2:0] S_LG_MUL  = 3'd5;
    localparam logic [2:0] S_RG_MUL  = 3'd6;
    localparam logic [2:0] S_WB      = 3'd7;

    localparam logic [AW-1:0]      TBL_TOP  = AW'(lcpp_pkg::TBL_SIZE);
    localparam logic signed [17:0] PAN_HI   = 18'sd32767;
    localparam logic signed [17:0] PAN_LO   = -18'sd32768;
    localparam logic [16:0]        IDX_BIAS = 17'(1 << (15 - A));

    // Config registers
    logic signed [lcpp_pkg::PAN_WIDTH-1:0]  r_base_pan;
    logic [lcpp_pkg::DEPTH_WIDTH-1:0]       r_depth;
    logic [lcpp_pkg::INC_WIDTH-1:0]         r_inc;
    logic                                   r_lfo_en;

    // Control and datapath registers
    logic [2:0]                 r_state, n_state;
    logic [PW-1:0]              r_phase;
    logic [AW-1:0]              r_rom_addr, n_rom_addr;
    logic [AW-1:0]              r_ridx, n_ridx;
    logic                       r_neg;
    logic signed [SW-1:0]       r_left_in, r_right_in;
    logic signed [SW-1:0]       r_left_res;
    logic                       r_out_valid;
    logic signed [SW-1:0]       r_left_out, r_right_out;

    logic                       in_acc;
    logic                       out_free;
    logic [A+1:0]               phase_top;
    logic [A-1:0]               lfo_idx;
    logic [AW-1:0]              lfo_addr;
    logic [GW-1:0]              rom_q;
    logic signed [GW-1:0]       sine_s;
    logic                       mul_en;
    logic signed [SW-1:0]       mul_a;
    logic signed [GW-1:0]       mul_b;
    logic signed [lcpp_pkg::PROD_WIDTH-1:0] prod;
    logic signed [lcpp_pkg::PROD_WIDTH-1:0] prod_rnd;
    logic signed [17:0]         pan_sum;
    logic signed [lcpp_pkg::PAN_WIDTH-1:0]  pan;
    logic [16:0]                idx_sum;
    logic [AW-1:0]              ridx;

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    // LFO table address from the current phase
    assign phase_top = r_phase[PW-1:SH];
    assign lfo_idx   = phase_top[A-1:0];
    assign lfo_addr  = phase_top[A] ? (TBL_TOP - AW'(lfo_idx)) : AW'(lfo_idx);

    // Shared units
    lcpp_sine_rom u_rom (
        .i_clk  (i_clk),
        .i_addr (r_rom_addr),
        .o_data (rom_q)
    );

    lcpp_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (mul_en),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // Multiplier operand select
    assign sine_s = r_neg ? -$signed(rom_q) : $signed(rom_q);

    always_comb begin
        mul_en = 1'b0;
        mul_a  = r_left_in;
        mul_b  = $signed(rom_q);
        case (r_state)
            S_MOD_MUL: begin
                mul_en = 1'b1;
                mul_a  = $signed(SW'(r_depth));
                mul_b  = sine_s;
            end
            S_LG_MUL: begin
                mul_en = 1'b1;
            end
            S_RG_MUL: begin
                mul_en = 1'b1;
                mul_a  = r_right_in;
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    // Round half up by 2^15
    assign prod_rnd = (prod + lcpp_pkg::PROD_WIDTH'(16384)) >>> 15;

    // Pan, clamp and right gain index; the modulation term is signed
    always_comb begin
        pan_sum = 18'(r_base_pan) + $signed(prod_rnd[17:0]);
        if (!r_lfo_en) begin
            pan = r_base_pan;
        end else if (pan_sum > PAN_HI) begin
            pan = PAN_HI[15:0];
        end else if (pan_sum < PAN_LO) begin
            pan = PAN_LO[15:0];
        end else begin
            pan = pan_sum[15:0];
        end
        idx_sum = {1'b0, ~pan[15], pan[14:0]} + IDX_BIAS;
        ridx    = idx_sum[16 -: AW];
    end

    // Sequencer next state
    always_comb begin
        n_state    = r_state;
        n_rom_addr = r_rom_addr;
        n_ridx     = r_ridx;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state    = S_SIN_RD;
                    n_rom_addr = lfo_addr;
                end
            end
            S_SIN_RD:  n_state = S_MOD_MUL;
            S_MOD_MUL: n_state = S_PAN;
            S_PAN: begin
                n_state    = S_LG_RD;
                n_ridx     = ridx;
                n_rom_addr = TBL_TOP - ridx;
            end
            S_LG_RD: begin
                n_state    = S_LG_MUL;
                n_rom_addr = r_ridx;
            end
            S_LG_MUL:  n_state = S_RG_MUL;
            S_RG_MUL:  n_state = S_WB;
            S_WB: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= '0;
            r_base_pan  <= '0;
            r_depth     <= '0;
            r_inc       <= '0;
            r_lfo_en    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_acc) begin
                r_phase <= r_phase + PW'(r_inc);
            end
            if (i_cfg_wr_en) begin
                case (i_cfg_addr)
                    lcpp_pkg::REG_BASE_PAN:  r_base_pan <= i_cfg_wdata[lcpp_pkg::PAN_WIDTH-1:0];
                    lcpp_pkg::REG_LFO_DEPTH: r_depth    <= i_cfg_wdata[lcpp_pkg::DEPTH_WIDTH-1:0];
                    lcpp_pkg::REG_LFO_INC:   r_inc      <= i_cfg_wdata[lcpp_pkg::INC_WIDTH-1:0];
                    lcpp_pkg::REG_LFO_EN:    r_lfo_en   <= i_cfg_wdata[0];
                    default: begin
                    end
                endcase
            end
            if (r_state == S_WB && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_rom_addr <= n_rom_addr;
        r_ridx     <= n_ridx;
        if (in_acc) begin
            r_left_in  <= i_left_sample;
            r_right_in <= i_right_sample;
            r_neg      <= phase_top[A+1];
        end
        if (r_state == S_RG_MUL) begin
            r_left_res <= prod_rnd[SW-1:0];
        end
        if (r_state == S_WB && out_free) begin
            r_left_out  <= r_left_res;
            r_right_out <= prod_rnd[SW-1:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_left_out  = r_left_out;
    assign o_right_out = r_right_out;

endmodule

/* src/lcpp_checker.sv */
// Port-level checker for the panner, bound to the top level
module lcpp_checker (
    input logic                                      i_clk,
    input logic                                      i_rst_n,
    input logic                                      i_in_valid,
    input logic                                      o_in_ready,
    input logic                                      o_out_valid,
    input logic                                      i_out_ready,
    input logic signed [lcpp_pkg::SAMPLE_WIDTH-1:0]  o_left_out,
    input logic signed [lcpp_pkg::SAMPLE_WIDTH-1:0]  o_right_out
);

    // Reset empties the output register
    a_rst_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // One pair in work at a time
    a_busy_after_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input ready straight after a transaction");

    // A new result only appears as the sequencer finishes a pair
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result appeared with no pair in work");

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_left_out) && $stable(o_right_out))
        else $error("stalled result changed");

endmodule

bind lfo_constant_power_panner_top lcpp_checker u_lcpp_checker (.*);

/* dv/tb.sv */
// Self-checking testbench for the LFO constant-power stereo panner
`timescale 1ns / 100ps

module tb;
    import lcpp_pkg::*;

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef struct packed {
        sample_t left;
        sample_t right;
    } stereo_t;

    localparam int CycleLimit   = 400000;
    localparam int SettleCycles = 12;
    localparam int HoldCycles   = 400;
    localparam int MaxReports   = 10;
    localparam int IdxShift     = 16 - SINE_ADDR_BITS;
    localparam int IdxHalf      = 1 << (15 - SINE_ADDR_BITS);

    // Predictor and store of expected gained pairs
    class pan_scoreboard;
        int                          sine_q15 [0:TBL_SIZE];
        logic [PHASE_WIDTH-1:0]      lfo_phase;
        logic signed [PAN_WIDTH-1:0] base_pan;
        logic [DEPTH_WIDTH-1:0]      lfo_depth;
        logic [INC_WIDTH-1:0]        lfo_inc;
        logic                        lfo_on;
        stereo_t                     expected_pairs [$];
        int                          mismatches;

        function new();
            longint unsigned step_k;
            longint unsigned x;
            longint unsigned x2;
            longint unsigned term;
            longint          acc;
            longint          q;
            // Quarter-wave sine in Q1.15 from an integer Q30 Taylor series
            for (int k = 0; k <= TBL_SIZE; k++) begin
                step_k = k;
                x      = (step_k * 64'd1686629713) >> SINE_ADDR_BITS;
                x2     = (x * x) >> 30;
                term   = x;
                acc    = longint'(x);
                for (int n = 1; n <= 7; n++) begin
                    term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
                    if (n % 2 == 1) begin
                        acc = acc - longint'(term);
                    end else begin
                        acc = acc + longint'(term);
                    end
                end
                if (acc < 0) begin
                    acc = 0;
                end
                q = (acc + 64'sd16384) >>> 15;
                if (q > 32767) begin
                    q = 32767;
                end
                sine_q15[k] = int'(q);
            end
            lfo_phase  = '0;
            base_pan   = '0;
            lfo_depth  = '0;
            lfo_inc    = '0;
            lfo_on     = 1'b0;
            mismatches = 0;
        endfunction

        function void set_reg(logic [CFG_ADDR_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] data);
            case (idx)
                REG_BASE_PAN:  base_pan  = data[PAN_WIDTH-1:0];
                REG_LFO_DEPTH: lfo_depth = data[DEPTH_WIDTH-1:0];
                REG_LFO_INC:   lfo_inc   = data[INC_WIDTH-1:0];
                REG_LFO_EN:    lfo_on    = data[0];
                default: ;
            endcase
        endfunction

        // Truncated table lookup, quadrant from the top two phase bits
        function int lfo_sine_at();
            logic [SINE_ADDR_BITS-1:0] idx;
            logic [1:0]                quad;
            int                        v;
            idx  = lfo_phase[PHASE_WIDTH-3 -: SINE_ADDR_BITS];
            quad = lfo_phase[PHASE_WIDTH-1 -: 2];
            v    = quad[0] ? sine_q15[TBL_SIZE - idx] : sine_q15[idx];
            return quad[1] ? -v : v;
        endfunction

        function void note_pair(sample_t l, sample_t r);
            longint  pan;
            longint  swing;
            longint  lp;
            longint  rp;
            int      ridx;
            stereo_t want;
            pan = longint'(base_pan);
            if (lfo_on) begin
                swing = (longint'(lfo_depth) * longint'(lfo_sine_at()) + 64'sd16384) >>> 15;
                pan   = pan + swing;
                if (pan > 32767) begin
                    pan = 32767;
                end
                if (pan < -32768) begin
                    pan = -32768;
                end
            end
            ridx = int'((pan + 32768 + IdxHalf) >>> IdxShift);
            if (ridx > TBL_SIZE) begin
                ridx = TBL_SIZE;
            end
            // cos gain on the left, sin gain on the right, rounded half up
            lp         = (longint'(l) * sine_q15[TBL_SIZE - ridx] + 64'sd16384) >>> 15;
            rp         = (longint'(r) * sine_q15[ridx] + 64'sd16384) >>> 15;
            want.left  = lp[SAMPLE_WIDTH-1:0];
            want.right = rp[SAMPLE_WIDTH-1:0];
            expected_pairs.push_back(want);
            // phase moves on every sample, modulated or not
            lfo_phase = lfo_phase + PHASE_WIDTH'(lfo_inc);
        endfunction

        function void flag(string what, longint want, longint got);
            mismatches++;
            if (mismatches <= MaxReports) begin
                $display("[%0t] %s: expected %0d, got %0d", $realtime, what, want, got);
            end
        endfunction

        function void check_pair(sample_t l, sample_t r);
            stereo_t want;
            if (expected_pairs.size() == 0) begin
                flag("output pair with nothing pending, left", 0, l);
                return;
            end
            want = expected_pairs.pop_front();
            if (l !== want.left) begin
                flag("left_out", want.left, l);
            end
            if (r !== want.right) begin
                flag("right_out", want.right, r);
            end
        endfunction

        function int pending();
            return expected_pairs.size();
        endfunction
    endclass

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_wr_en;
    logic [CFG_ADDR_WIDTH-1:0] i_cfg_addr;
    logic [CFG_DATA_WIDTH-1:0] i_cfg_wdata;
    logic                      i_in_valid;
    logic                      o_in_ready;
    sample_t                   i_left_sample;
    sample_t                   i_right_sample;
    logic                      o_out_valid;
    logic                      i_out_ready;
    sample_t                   o_left_out;
    sample_t                   o_right_out;

    pan_scoreboard sb = new();
    int            press_req = 0;
    int            corner_idx = 0;

    lfo_constant_power_panner_top DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_left_sample  (i_left_sample),
        .i_right_sample (i_right_sample),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_left_out     (o_left_out),
        .o_right_out    (o_right_out)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        repeat (CycleLimit) @(posedge i_clk);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Transaction monitors on both channels
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            sb.note_pair(i_left_sample, i_right_sample);
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_pair(o_left_out, o_right_out);
        end
    end

    // Receiver: rotating stall pattern, re-rolled now and then, plus long holds on request
    initial begin : receiver
        logic [15:0] pat;
        int          pat_age;
        int          hold_left;
        int          press_ack;
        pat         = 16'hFFFF;
        pat_age     = 0;
        hold_left   = 0;
        press_ack   = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (press_req != press_ack) begin
                press_ack = press_req;
                hold_left = HoldCycles;
            end
            if (pat_age == 0) begin
                pat_age = 97;
                case ($urandom_range(0, 3))
                    0: pat = 16'hFFFF;
                    1: pat = 16'($urandom);
                    2: pat = 16'($urandom | $urandom);
                    default: pat = 16'($urandom & $urandom) | 16'h0001;
                endcase
            end
            pat_age = pat_age - 1;
            pat     = {pat[0], pat[15:1]};
            if (hold_left != 0) begin
                hold_left   = hold_left - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= pat[0];
            end
        end
    end

    function automatic sample_t pick_sample();
        case ($urandom_range(0, 9))
            0: return {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
            1: return {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
            2: return sample_t'(int'($urandom_range(0, 512)) - 256);
            3: return '0;
            default: return sample_t'($urandom);
        endcase
    endfunction

    // Offer one pair and hold it until the transaction completes
    task automatic push_pair(sample_t l, sample_t r);
        i_in_valid     <= 1'b1;
        i_left_sample  <= l;
        i_right_sample <= r;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // Write all four registers, sometimes with junk above each register's width
    task automatic write_regs(logic signed [PAN_WIDTH-1:0] pan, logic [DEPTH_WIDTH-1:0] depth,
                              logic [INC_WIDTH-1:0] inc, logic en);
        logic [CFG_ADDR_WIDTH-1:0] ids   [4];
        logic [CFG_DATA_WIDTH-1:0] words [4];
        logic [CFG_DATA_WIDTH-1:0] keep  [4];
        ids   = '{REG_BASE_PAN, REG_LFO_DEPTH, REG_LFO_INC, REG_LFO_EN};
        words = '{CFG_DATA_WIDTH'(pan), CFG_DATA_WIDTH'(depth), CFG_DATA_WIDTH'(inc),
                  CFG_DATA_WIDTH'(en)};
        keep  = '{31'h0000FFFF, 31'h00007FFF, 31'h7FFFFFFF, 31'h00000001};
        for (int i = 0; i < 4; i++) begin
            words[i] = words[i] & keep[i];
            if ($urandom_range(0, 1) == 1) begin
                words[i] = words[i] | (CFG_DATA_WIDTH'($urandom) & ~keep[i]);
            end
            i_cfg_wr_en <= 1'b1;
            i_cfg_addr  <= ids[i];
            i_cfg_wdata <= words[i];
            @(posedge i_clk);
            sb.set_reg(ids[i], words[i]);
        end
        i_cfg_wr_en <= 1'b0;
    endtask

    // Wait for every pending pair, then let the pipeline go quiet
    task automatic settle();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    // Back-to-back corner samples: full scale both signs, the smallest steps, zero and half scale
    task automatic directed_run(int n);
        sample_t lefts  [6];
        sample_t rights [6];
        lefts  = '{24'h7FFFFF, 24'h800000, 24'h000001, 24'hFFFFFF, 24'h000000, 24'h400000};
        rights = '{24'h800000, 24'h7FFFFF, 24'hFFFFFF, 24'h000001, 24'h000000, 24'hC00000};
        for (int i = 0; i < n; i++) begin
            push_pair(lefts[corner_idx], rights[corner_idx]);
            corner_idx = (corner_idx + 1) % 6;
        end
        i_in_valid <= 1'b0;
        settle();
    endtask

    // Random pairs in bursts; optionally ask the receiver for a long hold
    task automatic random_run(int n, bit gaps_on, bit squeeze);
        int sent;
        int burst;
        int gap;
        if (squeeze) begin
            press_req <= press_req + 1;
        end
        sent = 0;
        while (sent < n) begin
            burst = $urandom_range(1, 16);
            for (int b = 0; b < burst && sent < n; b++) begin
                push_pair(pick_sample(), pick_sample());
                sent++;
            end
            gap = gaps_on ? $urandom_range(0, 10) : 0;
            if (gap != 0 || sent == n) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        settle();
    endtask

    // Main sequence
    initial begin : stimulus
        logic signed [PAN_WIDTH-1:0] pan_pick;
        logic [DEPTH_WIDTH-1:0]      depth_pick;
        logic [INC_WIDTH-1:0]        inc_pick;
        logic                        en_pick;
        i_rst_n        <= 1'b0;
        i_cfg_wr_en    <= 1'b0;
        i_cfg_addr     <= '0;
        i_cfg_wdata    <= '0;
        i_in_valid     <= 1'b0;
        i_left_sample  <= '0;
        i_right_sample <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Static pan: hard left, hard right, centre
        write_regs(16'sh8000, '0, '0, 1'b0);
        directed_run(3);
        write_regs(16'sh7FFF, '0, '0, 1'b0);
        directed_run(3);
        write_regs(16'sh0000, '0, '0, 1'b0);
        directed_run(3);
        // Quarter-cycle steps at full depth: clamps at the top, then at the bottom
        write_regs(16'sd20000, 15'h7FFF, 31'h40000000, 1'b1);
        directed_run(4);
        write_regs(-16'sd20000, 15'h7FFF, 31'h40000000, 1'b1);
        directed_run(4);
        // Fastest LFO from hard left
        write_regs(16'sh8000, 15'h7FFF, 31'h7FFFFFFF, 1'b1);
        directed_run(4);

        // Random phases, each with its own settings
        for (int p = 0; p < 10; p++) begin
            case ($urandom_range(0, 5))
                0: pan_pick = 16'sh8000;
                1: pan_pick = 16'sh7FFF;
                2: pan_pick = '0;
                default: pan_pick = PAN_WIDTH'($urandom);
            endcase
            case ($urandom_range(0, 3))
                0: depth_pick = '0;
                1: depth_pick = 15'h7FFF;
                default: depth_pick = DEPTH_WIDTH'($urandom);
            endcase
            case ($urandom_range(0, 4))
                0: inc_pick = '0;
                1: inc_pick = 31'h7FFFFFFF;
                2: inc_pick = INC_WIDTH'($urandom_range(0, 1 << 22));
                default: inc_pick = INC_WIDTH'($urandom);
            endcase
            en_pick = ($urandom_range(0, 3) != 0);
            // modulation on with zero depth, and full depth at the fastest rate
            if (p == 0) begin
                depth_pick = '0;
                en_pick    = 1'b1;
            end else if (p == 1) begin
                depth_pick = 15'h7FFF;
                inc_pick   = 31'h7FFFFFFF;
                en_pick    = 1'b1;
            end
            write_regs(pan_pick, depth_pick, inc_pick, en_pick);
            random_run(160, (p % 4) != 3, (p == 2) || (p == 7));
        end

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* lfo_constant_power_panner_top.f */
src/lcpp_pkg.sv
src/lcpp_sine_rom.sv
src/lcpp_mul.sv
src/lfo_constant_power_panner_top.sv
src/lcpp_checker.sv
dv/tb.sv
